FILE: sv/pps_pkg.sv
// Package for the preemptive priority scheduler: sizes, process entry type and states.
`default_nettype none
package pps_pkg;

  // Batch capacity and the widths that follow from it.
  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  // Fixed field widths of the request and result channels.
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int URG_W   = 8;
  localparam int TIME_W  = 23;
  localparam int SPAN_W  = 22;
  localparam int PNUM_W  = 7;

  // One stored process.
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [URG_W-1:0]   urgency;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  finish;
  } entry_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_APPLY  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/pps_if.sv
// Channel interfaces for process requests and scheduling results.
`default_nettype none
interface pps_proc_if;
  import pps_pkg::*;
  logic               valid;
  logic               ready;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_length;
  logic [URG_W-1:0]   urgency;
  logic               last_process;

  modport source (output valid, arrival_time, burst_length, urgency, last_process,
                  input ready);
  modport sink (input valid, arrival_time, burst_length, urgency, last_process,
                output ready);
endinterface

interface pps_result_if;
  import pps_pkg::*;
  logic              valid;
  logic              ready;
  logic [PNUM_W-1:0] process_number;
  logic [TIME_W-1:0] finish_time;
  logic [SPAN_W-1:0] turnaround;
  logic [SPAN_W-1:0] wait_time;
  logic              last_result;

  modport source (output valid, process_number, finish_time, turnaround, wait_time,
                  last_result, input ready);
  modport sink (input valid, process_number, finish_time, turnaround, wait_time,
                last_result, output ready);
endinterface
`default_nettype wire

FILE: sv/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: process store, scan sequencer and result register.
// Loading accepts one request per cycle; the request marked last starts scheduling.
// Each event of a batch of n processes scans all n entries through the shared compare unit,
// then sizes the run and applies it, or jumps to the next arrival when nothing is ready.
// Results then leave at one per cycle while the receiver is ready, and the next batch loads while the last one waits.
// Synchronous reset returns the block to loading with an empty batch.
`default_nettype none
module preemptive_priority_scheduler_top (
  input  wire logic clk,
  input  wire logic rst,
  pps_proc_if.sink     proc_in,
  pps_result_if.source result_out
);
  import pps_pkg::*;

  // Process store, read at a single index.
  entry_t store [MAX_PROCESSES];

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   n_count;
  logic [CNT_W-1:0]   done_count;
  logic [CNT_W-1:0]   idx;
  logic [TIME_W-1:0]  cur;

  // Best candidate and nearest future arrival of the current scan.
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [URG_W-1:0]   best_urg;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_rem;
  logic               next_valid;
  logic [ARR_W-1:0]   next_arr;
  logic [BURST_W-1:0] run_len;

  // Output register.
  logic               out_valid;
  logic [PNUM_W-1:0]  out_pnum;
  logic [TIME_W-1:0]  out_fin;
  logic [SPAN_W-1:0]  out_tat;
  logic [SPAN_W-1:0]  out_wt;
  logic               out_last;

  entry_t             rd;
  logic               live;
  logic               arrived;
  logic               better;
  logic               earlier;
  logic               idx_last;
  logic               stored;
  logic [BURST_W-1:0] burst_fix;
  logic [ARR_W-1:0]   gap;
  logic [TIME_W-1:0]  cur_sum;
  logic [BURST_W-1:0] rem_left;
  logic [TIME_W-1:0]  tat_full;
  logic [TIME_W-1:0]  wt_full;
  logic               emit_go;

  // Single read port and the shared compare unit of the scan.
  always_comb begin
    rd       = store[idx[IDX_W-1:0]];
    live     = (rd.remaining != '0);
    arrived  = (TIME_W'(rd.arrival) <= cur);
    better   = !found || (rd.urgency < best_urg) ||
               ((rd.urgency == best_urg) && (rd.arrival < best_arr));
    earlier  = !next_valid || (rd.arrival < next_arr);
    idx_last = (CNT_W'(idx + 1'b1) == n_count);
  end

  // Loading, run sizing, run application and result arithmetic.
  always_comb begin
    stored    = (count < CNT_W'(MAX_PROCESSES));
    burst_fix = (proc_in.burst_length == '0) ? BURST_W'(1) : proc_in.burst_length;
    gap       = next_arr - cur[ARR_W-1:0];
    cur_sum   = cur + TIME_W'(run_len);
    rem_left  = best_rem - run_len;
    tat_full  = rd.finish - TIME_W'(rd.arrival);
    wt_full   = tat_full - TIME_W'(rd.burst);
    emit_go   = !out_valid || result_out.ready;
  end

  assign proc_in.ready = (state == ST_LOAD);

  assign result_out.valid          = out_valid;
  assign result_out.process_number = out_pnum;
  assign result_out.finish_time    = out_fin;
  assign result_out.turnaround     = out_tat;
  assign result_out.wait_time      = out_wt;
  assign result_out.last_result    = out_last;

  // Store writes: new processes while loading, progress while applying a run.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && proc_in.valid && stored) begin
      store[count[IDX_W-1:0]].arrival   <= proc_in.arrival_time;
      store[count[IDX_W-1:0]].burst     <= burst_fix;
      store[count[IDX_W-1:0]].urgency   <= proc_in.urgency;
      store[count[IDX_W-1:0]].remaining <= burst_fix;
    end else if (state == ST_APPLY) begin
      store[best_idx].remaining <= rem_left;
      if (rem_left == '0) begin
        store[best_idx].finish <= cur_sum;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      n_count    <= '0;
      done_count <= '0;
      idx        <= '0;
      cur        <= '0;
      found      <= 1'b0;
      next_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The result register fills while emitting and empties once its result is taken.
      if (state == ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (proc_in.valid) begin
            if (stored) begin
              count <= CNT_W'(count + 1'b1);
            end
            if (proc_in.last_process) begin
              n_count    <= stored ? CNT_W'(count + 1'b1) : count;
              done_count <= '0;
              cur        <= '0;
              idx        <= '0;
              found      <= 1'b0;
              next_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (live && arrived && better) begin
            found    <= 1'b1;
            best_idx <= idx[IDX_W-1:0];
            best_urg <= rd.urgency;
            best_arr <= rd.arrival;
            best_rem <= rd.remaining;
          end
          if (live && !arrived && earlier) begin
            next_valid <= 1'b1;
            next_arr   <= rd.arrival;
          end
          if (idx_last) begin
            state <= ST_DECIDE;
          end else begin
            idx <= CNT_W'(idx + 1'b1);
          end
        end
        ST_DECIDE: begin
          if (!found) begin
            // Nothing ready: jump to the next arrival and scan again.
            cur        <= TIME_W'(next_arr);
            idx        <= '0;
            next_valid <= 1'b0;
            state      <= ST_SCAN;
          end else begin
            // Run until completion or the next arrival, whichever is sooner.
            run_len <= (next_valid && (gap < best_rem)) ? gap : best_rem;
            state   <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          cur        <= cur_sum;
          idx        <= '0;
          found      <= 1'b0;
          next_valid <= 1'b0;
          if (rem_left == '0) begin
            done_count <= CNT_W'(done_count + 1'b1);
            if (CNT_W'(done_count + 1'b1) == n_count) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_SCAN;
            end
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_pnum  <= PNUM_W'(PNUM_W'(idx) + 1'b1);
            out_fin   <= rd.finish;
            out_tat   <= tat_full[SPAN_W-1:0];
            out_wt    <= wt_full[SPAN_W-1:0];
            out_last  <= idx_last;
            if (idx_last) begin
              count <= '0;
              cur   <= '0;
              state <= ST_LOAD;
            end else begin
              idx <= CNT_W'(idx + 1'b1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
